// ===== rtl/core/sh9_pkg.sv =====
`timescale 1ns / 1ps

package sh9_pkg;

  localparam int SLOTS      = 9;
  localparam int CHANNELS   = 3;
  localparam int GROUP_SIZE = 3;
  localparam int GROUPS     = SLOTS / GROUP_SIZE;

  localparam int IDX_W   = 4;
  localparam int COEF_W  = 32;
  localparam int DIR_W   = 16;
  localparam int IRR_W   = 32;

  // basis terms are Q.30, 3z^2-1 reaches 2^31 so one extra bit
  localparam int BASIS_W  = 33;
  localparam int WEIGHT_W = 26;
  localparam int WPROD_W  = BASIS_W + WEIGHT_W;
  localparam int PROD_W   = 58;
  localparam int GROUP_W  = 60;
  localparam int ACC_W    = 61;

  localparam int LIN_SHIFT = 15;
  localparam int W_SHIFT   = 30;
  localparam int RES_SHIFT = 24;
  localparam int RES_W     = ACC_W - RES_SHIFT;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [DIR_W-1:0]    dir_t;
  typedef logic signed [BASIS_W-1:0]  basis_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [GROUP_W-1:0]  group_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [IRR_W-1:0]           irr_t;

  typedef struct packed {
    logic             valid;
    cmd_t             cmd;
    logic [IDX_W-1:0] index;
  } ctl_t;

  localparam basis_t BASIS_ONE = 33'sd1073741824;

  // sh normalisation times clamped-cosine band factor, Q.24
  localparam weight_t BAND_WEIGHT [SLOTS] = '{
    26'sd14868421, 26'sd17168573, 26'sd17168573, 26'sd17168573,
    26'sd14396286, 26'sd14396286, 26'sd4155850,  26'sd14396286,
    26'sd7198143
  };

endpackage

// ===== rtl/core/sh9_in_if.sv =====
`timescale 1ns / 1ps

interface sh9_in_if ();
  import sh9_pkg::*;

  logic                    valid;
  logic                    ready;
  cmd_t                    cmd;
  logic [IDX_W-1:0]        coef_index;
  logic signed [COEF_W-1:0] coef_red;
  logic signed [COEF_W-1:0] coef_green;
  logic signed [COEF_W-1:0] coef_blue;
  logic signed [DIR_W-1:0]  dir_x;
  logic signed [DIR_W-1:0]  dir_y;
  logic signed [DIR_W-1:0]  dir_z;

  modport source (
    output valid, cmd, coef_index, coef_red, coef_green, coef_blue, dir_x, dir_y, dir_z,
    input  ready
  );

  modport sink (
    input  valid, cmd, coef_index, coef_red, coef_green, coef_blue, dir_x, dir_y, dir_z,
    output ready
  );

endinterface

// ===== rtl/core/sh9_out_if.sv =====
`timescale 1ns / 1ps

interface sh9_out_if ();
  import sh9_pkg::*;

  logic             valid;
  logic             ready;
  logic [IRR_W-1:0] irr_red;
  logic [IRR_W-1:0] irr_green;
  logic [IRR_W-1:0] irr_blue;

  modport source (
    output valid, irr_red, irr_green, irr_blue,
    input  ready
  );

  modport sink (
    input  valid, irr_red, irr_green, irr_blue,
    output ready
  );

endinterface

// ===== rtl/core/sh9_irradiance_evaluate.sv =====
// channel  dir  transaction
// item     in   load (cmd, coef_index, coef_red/green/blue) or evaluate (dir_x/y/z)
// result   out  irr_red, irr_green, irr_blue, one per evaluate, none per load
//
// one transaction per cycle while no result waits untaken
// path: input reg, basis products, band weights, 27 coefficient multipliers, partial
// sums, final sum with round and clamp into the output register
// reset clears the 27-word coefficient store at once; the store is written by a load
// when it reaches the multiplier stage, so transactions act in arrival order
// while a result waits untaken the whole pipeline holds and ready drops
`timescale 1ns / 1ps

module sh9_irradiance_evaluate (
  input  logic      clk,
  input  logic      rst,
  sh9_in_if.sink    item,
  sh9_out_if.source result
);
  import sh9_pkg::*;

  logic    advance;
  ctl_t    c_ctl;
  coef_t   c_coef [CHANNELS];
  weight_t c_weight [SLOTS];
  logic    e_valid;
  group_t  e_sum [CHANNELS][GROUPS];

  assign advance = !result.valid || result.ready;

  sh9_basis u_basis (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .ctl     (c_ctl),
    .coef    (c_coef),
    .weight  (c_weight)
  );

  sh9_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .ctl       (c_ctl),
    .coef      (c_coef),
    .weight    (c_weight),
    .sum_valid (e_valid),
    .part_sum  (e_sum)
  );

  sh9_sum_clamp u_sum_clamp (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .sum_valid (e_valid),
    .part_sum  (e_sum),
    .result    (result)
  );

endmodule

// ===== rtl/core/sh9_basis.sv =====
`timescale 1ns / 1ps

module sh9_basis (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  sh9_in_if.sink           item,
  output sh9_pkg::ctl_t    ctl,
  output sh9_pkg::coef_t   coef [sh9_pkg::CHANNELS],
  output sh9_pkg::weight_t weight [sh9_pkg::SLOTS]
);
  import sh9_pkg::*;

  ctl_t   a_ctl;
  coef_t  a_coef [CHANNELS];
  dir_t   a_x;
  dir_t   a_y;
  dir_t   a_z;

  ctl_t   b_ctl;
  coef_t  b_coef [CHANNELS];
  basis_t b_t [SLOTS];

  logic signed [2*DIR_W-1:0] xx, yy, zz, xy, yz, xz;
  basis_t                    t_next [SLOTS];
  logic signed [WPROD_W-1:0] wprod [SLOTS];
  weight_t                   w_next [SLOTS];

  assign item.ready = advance;

  // quadratic products and the Q.30 basis terms
  always_comb begin
    xx = a_x * a_x;
    yy = a_y * a_y;
    zz = a_z * a_z;
    xy = a_x * a_y;
    yz = a_y * a_z;
    xz = a_x * a_z;
    t_next[0] = BASIS_ONE;
    t_next[1] = BASIS_W'(a_y) <<< LIN_SHIFT;
    t_next[2] = BASIS_W'(a_z) <<< LIN_SHIFT;
    t_next[3] = BASIS_W'(a_x) <<< LIN_SHIFT;
    t_next[4] = BASIS_W'(xy);
    t_next[5] = BASIS_W'(yz);
    t_next[6] = BASIS_W'(zz) + (BASIS_W'(zz) <<< 1) - BASIS_ONE;
    t_next[7] = BASIS_W'(xz);
    t_next[8] = BASIS_W'(xx) - BASIS_W'(yy);
  end

  // band weighting, rounded half up back to Q.24
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      wprod[i]  = WPROD_W'(b_t[i]) * WPROD_W'(BAND_WEIGHT[i]);
      w_next[i] = WEIGHT_W'((wprod[i] + (WPROD_W'(1) <<< (W_SHIFT - 1))) >>> W_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
      b_ctl <= '0;
      ctl   <= '0;
    end else if (advance) begin
      a_ctl <= '{valid: item.valid, cmd: item.cmd, index: item.coef_index};
      b_ctl <= a_ctl;
      ctl   <= b_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_coef[0] <= item.coef_red;
      a_coef[1] <= item.coef_green;
      a_coef[2] <= item.coef_blue;
      a_x       <= item.dir_x;
      a_y       <= item.dir_y;
      a_z       <= item.dir_z;
      b_coef    <= a_coef;
      b_t       <= t_next;
      coef      <= b_coef;
      weight    <= w_next;
    end
  end

endmodule

// ===== rtl/core/sh9_dot.sv =====
`timescale 1ns / 1ps

module sh9_dot (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  sh9_pkg::ctl_t    ctl,
  input  sh9_pkg::coef_t   coef [sh9_pkg::CHANNELS],
  input  sh9_pkg::weight_t weight [sh9_pkg::SLOTS],
  output logic             sum_valid,
  output sh9_pkg::group_t  part_sum [sh9_pkg::CHANNELS][sh9_pkg::GROUPS]
);
  import sh9_pkg::*;

  coef_t  store [SLOTS][CHANNELS];
  logic   store_we;
  prod_t  prod_next [CHANNELS][SLOTS];
  prod_t  d_prod [CHANNELS][SLOTS];
  logic   d_valid;
  group_t grp_next [CHANNELS][GROUPS];

  // loads update the store at this stage so earlier evaluates never see them
  assign store_we = advance && ctl.valid && (ctl.cmd == CMD_LOAD) &&
                    (ctl.index < IDX_W'(SLOTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          store[s][c] <= '0;
        end
      end
    end else if (store_we) begin
      for (int c = 0; c < CHANNELS; c++) begin
        store[ctl.index][c] <= coef[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      for (int s = 0; s < SLOTS; s++) begin
        prod_next[c][s] = PROD_W'(store[s][c]) * PROD_W'(weight[s]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      for (int g = 0; g < GROUPS; g++) begin
        grp_next[c][g] = '0;
        for (int k = 0; k < GROUP_SIZE; k++) begin
          grp_next[c][g] = grp_next[c][g] + GROUP_W'(d_prod[c][g*GROUP_SIZE+k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      sum_valid <= 1'b0;
    end else if (advance) begin
      d_valid   <= ctl.valid && (ctl.cmd == CMD_EVAL);
      sum_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d_prod   <= prod_next;
      part_sum <= grp_next;
    end
  end

endmodule

// ===== rtl/core/sh9_sum_clamp.sv =====
`timescale 1ns / 1ps

module sh9_sum_clamp (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            sum_valid,
  input  sh9_pkg::group_t part_sum [sh9_pkg::CHANNELS][sh9_pkg::GROUPS],
  sh9_out_if.source       result
);
  import sh9_pkg::*;

  acc_t             acc [CHANNELS];
  logic [RES_W-1:0] shifted [CHANNELS];
  irr_t             irr_next [CHANNELS];
  irr_t             irr [CHANNELS];
  logic             f_valid;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      acc[c] = ACC_W'(1) <<< (RES_SHIFT - 1);
      for (int g = 0; g < GROUPS; g++) begin
        acc[c] = acc[c] + ACC_W'(part_sum[c][g]);
      end
      shifted[c] = RES_W'(acc[c] >>> RES_SHIFT);
      // clamp below zero, saturate above the q16.16 range
      if (acc[c][ACC_W-1]) begin
        irr_next[c] = '0;
      end else if (|shifted[c][RES_W-1:IRR_W]) begin
        irr_next[c] = '1;
      end else begin
        irr_next[c] = shifted[c][IRR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (advance) begin
      f_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      irr <= irr_next;
    end
  end

  assign result.valid     = f_valid;
  assign result.irr_red   = irr[0];
  assign result.irr_green = irr[1];
  assign result.irr_blue  = irr[2];

endmodule

// ===== bench/sh9_irradiance_check.sv =====
`timescale 1ns / 1ps

module sh9_irradiance_check (
  input  logic clk,
  input  logic rst,
  sh9_in_if    item_ch,
  sh9_out_if   result_ch,
  output int   errors,
  output int   outstanding
);
  import sh9_pkg::*;

  typedef logic [CHANNELS-1:0][IRR_W-1:0] rgb_t;

  // sh normalisation folded with the cosine lobe per band, q.24
  localparam longint FOLD_WEIGHT [SLOTS] = '{
    64'sd14868421, 64'sd17168573, 64'sd17168573, 64'sd17168573,
    64'sd14396286, 64'sd14396286, 64'sd4155850,  64'sd14396286,
    64'sd7198143
  };

  coef_t coef_store [SLOTS*CHANNELS];
  rgb_t  irradiance_q [$];
  rgb_t  want;
  int    fail_count = 0;
  int    pending = 0;

  assign errors      = fail_count;
  assign outstanding = pending;

  // arithmetic shift with rounding half towards +inf
  function automatic longint shift_round_up(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic rgb_t predict_irradiance(dir_t dx, dir_t dy, dir_t dz);
    longint x, y, z, acc, r;
    longint basis [SLOTS];
    longint wt [SLOTS];
    rgb_t   rgb;
    x = dx;
    y = dy;
    z = dz;
    basis[0] = longint'(1) << 30;
    basis[1] = y * 32768;
    basis[2] = z * 32768;
    basis[3] = x * 32768;
    basis[4] = x * y;
    basis[5] = y * z;
    basis[6] = 3 * z * z - (longint'(1) << 30);
    basis[7] = x * z;
    basis[8] = x * x - y * y;
    for (int i = 0; i < SLOTS; i++) wt[i] = shift_round_up(basis[i] * FOLD_WEIGHT[i], 30);
    for (int ch = 0; ch < CHANNELS; ch++) begin
      acc = 0;
      for (int i = 0; i < SLOTS; i++) acc += longint'(coef_store[i*CHANNELS + ch]) * wt[i];
      r = shift_round_up(acc, 24);
      if (r < 0) r = 0;
      if (r > longint'(64'hFFFF_FFFF)) r = longint'(64'hFFFF_FFFF);
      rgb[ch] = r[IRR_W-1:0];
    end
    return rgb;
  endfunction

  task automatic compare_field(string name, irr_t exp_val, irr_t act_val);
    if (act_val !== exp_val) begin
      fail_count++;
      $display("%0t: %s expected %h, got %h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (coef_store[i]) coef_store[i] = '0;
      irradiance_q.delete();
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (irradiance_q.size() == 0) begin
          fail_count++;
          $display("%0t: result expected none, got %h %h %h", $time,
                   result_ch.irr_red, result_ch.irr_green, result_ch.irr_blue);
        end else begin
          want = irradiance_q.pop_front();
          compare_field("irr_red", want[0], result_ch.irr_red);
          compare_field("irr_green", want[1], result_ch.irr_green);
          compare_field("irr_blue", want[2], result_ch.irr_blue);
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        if (item_ch.cmd == CMD_EVAL) begin
          irradiance_q = {irradiance_q, predict_irradiance(item_ch.dir_x, item_ch.dir_y,
                                                           item_ch.dir_z)};
        end else if (item_ch.coef_index < SLOTS) begin
          coef_store[item_ch.coef_index*CHANNELS + 0] = item_ch.coef_red;
          coef_store[item_ch.coef_index*CHANNELS + 1] = item_ch.coef_green;
          coef_store[item_ch.coef_index*CHANNELS + 2] = item_ch.coef_blue;
        end
      end
    end
    pending = irradiance_q.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import sh9_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 450;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst;
  int   errors;
  int   outstanding;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   cycle_count = 0;

  sh9_in_if  item_ch ();
  sh9_out_if result_ch ();

  sh9_irradiance_evaluate dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  sh9_irradiance_check irr_check (
    .clk         (clk),
    .rst         (rst),
    .item_ch     (item_ch),
    .result_ch   (result_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** sh9_irradiance_evaluate: FAILED **");
    $finish;
  end

  function automatic coef_t random_coef();
    case ($urandom_range(9))
      0, 1, 2, 3: return coef_t'(int'($urandom_range(524288)) - 262144);
      7:          return 32'sh7FFF_FFFF;
      8:          return 32'sh8000_0000;
      9:          return '0;
      default:    return coef_t'($urandom);
    endcase
  endfunction

  function automatic dir_t random_dir();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3, 4:    return dir_t'(int'($urandom_range(2048)) - 1024);
      default: return dir_t'($urandom);
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input cmd_t c, input logic [IDX_W-1:0] idx,
                           input coef_t r, g, b, input dir_t x, y, z);
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.cmd        <= c;
    item_ch.coef_index <= idx;
    item_ch.coef_red   <= r;
    item_ch.coef_green <= g;
    item_ch.coef_blue  <= b;
    item_ch.dir_x      <= x;
    item_ch.dir_y      <= y;
    item_ch.dir_z      <= z;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_slot(input logic [IDX_W-1:0] idx, input coef_t r, g, b);
    send_item(CMD_LOAD, idx, r, g, b, random_dir(), random_dir(), random_dir());
  endtask

  task automatic evaluate_dir(input dir_t x, y, z);
    send_item(CMD_EVAL, IDX_W'($urandom), random_coef(), random_coef(), random_coef(),
              x, y, z);
  endtask

  // sender holds off until every irradiance result has come back
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    cmd_t             c;
    logic [IDX_W-1:0] idx;
    idle_pct  = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      c = ($urandom_range(99) < 35) ? CMD_LOAD : CMD_EVAL;
      // mostly valid slots, now and then one past the store
      idx = ($urandom_range(19) == 0) ? IDX_W'($urandom_range(15, SLOTS))
                                      : IDX_W'($urandom_range(SLOTS - 1));
      send_item(c, idx, random_coef(), random_coef(), random_coef(),
                random_dir(), random_dir(), random_dir());
    end
    wait_drained();
  endtask

  initial begin
    rst                = 1'b1;
    result_ch.ready    = 1'b0;
    item_ch.valid      = 1'b0;
    item_ch.cmd        = CMD_LOAD;
    item_ch.coef_index = '0;
    item_ch.coef_red   = '0;
    item_ch.coef_green = '0;
    item_ch.coef_blue  = '0;
    item_ch.dir_x      = '0;
    item_ch.dir_y      = '0;
    item_ch.dir_z      = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // store is still all zero
    evaluate_dir(16'sh7FFF, 16'sh8000, 16'sh0000);
    load_slot(IDX_W'(0), 32'sh0001_0000, 32'shFFFF_0000, 32'sh7FFF_FFFF);
    evaluate_dir(16'sh0000, 16'sh0000, 16'sh0000);
    // slots past the store must leave it untouched
    load_slot(IDX_W'(15), 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    load_slot(IDX_W'(SLOTS), 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    evaluate_dir(16'sh0000, 16'sh0000, 16'sh0000);
    // red pushed to saturation, green driven negative
    for (int s = 1; s < SLOTS; s++) begin
      load_slot(IDX_W'(s), 32'sh7FFF_FFFF, 32'sh8000_0000, random_coef());
    end
    evaluate_dir(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    evaluate_dir(16'sh8000, 16'sh8000, 16'sh8000);
    evaluate_dir(16'sh0000, 16'sh8000, 16'sh0000);
    evaluate_dir(16'sh8000, 16'sh0000, 16'sh7FFF);
    evaluate_dir(16'sh0000, 16'sh0000, 16'sh8000);
    load_slot(IDX_W'(SLOTS - 1), '0, '0, '0);
    evaluate_dir(16'sh7FFF, 16'sh0000, 16'sh0000);
    evaluate_dir(16'sh5A82, 16'shA57E, 16'sh0000);
    wait_drained();

    run_phase(0, 0, PHASE_ITEMS);
    run_phase(48, 0, PHASE_ITEMS);
    run_phase(0, 48, PHASE_ITEMS);
    run_phase(6, 6, PHASE_ITEMS);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("** sh9_irradiance_evaluate: PASSED **");
    end else begin
      $display("** sh9_irradiance_evaluate: FAILED **");
    end
    $finish;
  end

endmodule
